### src/tcon_pkg.sv
// ----------------------------------------------------------------------------
// tcon_pkg
// Shared types and constants of the text console character engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcon_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int IDX_W  = $clog2(CELLS);
    localparam int CELL_W = 16;
    localparam int CLR_W  = 4;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_BLANK = 8'd32;

    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_MOVE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CUR_HOLD = 3'd0,
        CUR_MOVE = 3'd1,
        CUR_HOME = 3'd2,
        CUR_CR   = 3'd3,
        CUR_BS   = 3'd4,
        CUR_ADV  = 3'd5,
        CUR_NL   = 3'd6
    } cur_op_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic [7:0] col;
        logic [7:0] row;
    } item_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [IDX_W-1:0]  cursor_index;
        logic [CELL_W-1:0] cell_data;
    } result_t;

    typedef struct packed {
        logic    load;
        cur_op_t cur_op;
        logic    write_char;
        logic    read_issue;
        logic    sweep_clear;
        logic    copy_step;
        logic    blank_step;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       is_cr;
        logic       is_lf;
        logic       is_bs;
        logic       last_col;
        logic       last_row;
        logic       copy_last;
        logic       sweep_last;
    } stat_t;

endpackage

`default_nettype wire

### src/tcon_ram.sv
// ----------------------------------------------------------------------------
// tcon_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcon_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/tcon_dp.sv
// ----------------------------------------------------------------------------
// tcon_dp
// Datapath: item register, cursor, colours, sweep counter, screen memory
// and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcon_dp (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire tcon_pkg::item_t         s_item,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_addr,
    input  wire logic [tcon_pkg::CLR_W-1:0] cfg_wdata,
    input  wire tcon_pkg::cmd_t          cmd,
    output tcon_pkg::stat_t              stat,
    output tcon_pkg::result_t            result
);

    tcon_pkg::item_t               item_reg;
    logic [tcon_pkg::COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [tcon_pkg::ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [tcon_pkg::CLR_W-1:0]    fg_reg, bg_reg;
    logic [tcon_pkg::IDX_W-1:0]    sweep_reg;
    logic                          pend_reg;
    logic [tcon_pkg::IDX_W-1:0]    pend_addr_reg;
    tcon_pkg::result_t             result_reg;

    logic [tcon_pkg::COL_W-1:0]    col_c;
    logic [tcon_pkg::ROW_W-1:0]    row_c;
    logic [tcon_pkg::IDX_W-1:0]    cur_idx, rd_idx;
    logic [7:0]                    attr;
    logic                          ram_we, ram_re;
    logic [tcon_pkg::IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [tcon_pkg::CELL_W-1:0]   ram_wdata, ram_rdata;

    assign col_c = (item_reg.col > 8'(tcon_pkg::COLUMNS - 1))
                 ? tcon_pkg::COL_W'(tcon_pkg::COLUMNS - 1)
                 : item_reg.col[tcon_pkg::COL_W-1:0];
    assign row_c = (item_reg.row > 8'(tcon_pkg::ROWS - 1))
                 ? tcon_pkg::ROW_W'(tcon_pkg::ROWS - 1)
                 : item_reg.row[tcon_pkg::ROW_W-1:0];

    assign cur_idx = tcon_pkg::IDX_W'(cur_row_reg) * tcon_pkg::IDX_W'(tcon_pkg::COLUMNS)
                   + tcon_pkg::IDX_W'(cur_col_reg);
    assign rd_idx  = tcon_pkg::IDX_W'(row_c) * tcon_pkg::IDX_W'(tcon_pkg::COLUMNS)
                   + tcon_pkg::IDX_W'(col_c);
    assign attr    = {bg_reg, fg_reg};

    assign stat.op         = item_reg.op;
    assign stat.is_cr      = (item_reg.ch == tcon_pkg::CH_CR);
    assign stat.is_lf      = (item_reg.ch == tcon_pkg::CH_LF);
    assign stat.is_bs      = (item_reg.ch == tcon_pkg::CH_BS);
    assign stat.last_col   = (cur_col_reg == tcon_pkg::COL_W'(tcon_pkg::COLUMNS - 1));
    assign stat.last_row   = (cur_row_reg == tcon_pkg::ROW_W'(tcon_pkg::ROWS - 1));
    assign stat.copy_last  =
        (sweep_reg == tcon_pkg::IDX_W'(tcon_pkg::CELLS - tcon_pkg::COLUMNS - 1));
    assign stat.sweep_last = (sweep_reg == tcon_pkg::IDX_W'(tcon_pkg::CELLS - 1));

    always_comb begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        case (cmd.cur_op)
            tcon_pkg::CUR_HOLD: begin
            end
            tcon_pkg::CUR_MOVE: begin
                cur_col_next = col_c;
                cur_row_next = row_c;
            end
            tcon_pkg::CUR_HOME: begin
                cur_col_next = '0;
                cur_row_next = '0;
            end
            tcon_pkg::CUR_CR: begin
                cur_col_next = '0;
            end
            tcon_pkg::CUR_BS: begin
                if (cur_col_reg != '0) begin
                    cur_col_next = cur_col_reg - tcon_pkg::COL_W'(1);
                end else if (cur_row_reg != '0) begin
                    cur_row_next = cur_row_reg - tcon_pkg::ROW_W'(1);
                end
            end
            tcon_pkg::CUR_ADV: begin
                cur_col_next = cur_col_reg + tcon_pkg::COL_W'(1);
            end
            tcon_pkg::CUR_NL: begin
                cur_col_next = '0;
                cur_row_next = cur_row_reg + tcon_pkg::ROW_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ram_we    = pend_reg | cmd.write_char | cmd.blank_step;
        ram_waddr = sweep_reg;
        ram_wdata = {attr, tcon_pkg::CH_BLANK};
        if (pend_reg) begin
            ram_waddr = pend_addr_reg;
            ram_wdata = ram_rdata;
        end else if (cmd.write_char) begin
            ram_waddr = cur_idx;
            ram_wdata = {attr, item_reg.ch};
        end
        ram_re    = cmd.read_issue | cmd.copy_step;
        ram_raddr = cmd.copy_step ? sweep_reg + tcon_pkg::IDX_W'(tcon_pkg::COLUMNS) : rd_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            fg_reg      <= tcon_pkg::CLR_W'(15);
            bg_reg      <= '0;
            sweep_reg   <= '0;
            pend_reg    <= 1'b0;
        end else begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            pend_reg    <= cmd.copy_step;
            if (cfg_we && cfg_addr == tcon_pkg::REG_FG) begin
                fg_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == tcon_pkg::REG_BG) begin
                bg_reg <= cfg_wdata;
            end
            if (cmd.sweep_clear) begin
                sweep_reg <= '0;
            end else if (cmd.copy_step || cmd.blank_step) begin
                sweep_reg <= sweep_reg + tcon_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_item;
        end
        if (cmd.copy_step) begin
            pend_addr_reg <= sweep_reg;
        end
        if (cmd.out_load) begin
            result_reg.cursor_col   <= cur_col_reg;
            result_reg.cursor_row   <= cur_row_reg;
            result_reg.cursor_index <= cur_idx;
            result_reg.cell_data    <= (item_reg.op == tcon_pkg::OP_READ) ? ram_rdata : '0;
        end
    end

    assign result = result_reg;

    tcon_ram #(
        .WIDTH (tcon_pkg::CELL_W),
        .DEPTH (tcon_pkg::CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### src/tcon_ctrl.sv
// ----------------------------------------------------------------------------
// tcon_ctrl
// Controller: sequences decode, scroll, clear and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tcon_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire tcon_pkg::stat_t stat,
    output tcon_pkg::cmd_t       cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_SCROLL = 7'b0000100,
        S_FLUSH  = 7'b0001000,
        S_BLANK  = 7'b0010000,
        S_CLEAR  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   wrap;

    assign out_free = !m_valid_reg || m_ready;
    assign wrap     = stat.is_lf || (!stat.is_cr && !stat.is_bs && stat.last_col);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.cur_op = tcon_pkg::CUR_HOLD;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_DONE;
                case (stat.op)
                    tcon_pkg::OP_PUT: begin
                        if (stat.is_cr) begin
                            cmd.cur_op = tcon_pkg::CUR_CR;
                        end else if (stat.is_bs) begin
                            cmd.cur_op = tcon_pkg::CUR_BS;
                        end else begin
                            cmd.write_char = !stat.is_lf;
                            if (!wrap) begin
                                cmd.cur_op = tcon_pkg::CUR_ADV;
                            end else if (!stat.last_row) begin
                                cmd.cur_op = tcon_pkg::CUR_NL;
                            end else begin
                                cmd.cur_op      = tcon_pkg::CUR_CR;
                                cmd.sweep_clear = 1'b1;
                                state_next      = S_SCROLL;
                            end
                        end
                    end
                    tcon_pkg::OP_MOVE: begin
                        cmd.cur_op = tcon_pkg::CUR_MOVE;
                    end
                    tcon_pkg::OP_CLEAR: begin
                        cmd.cur_op      = tcon_pkg::CUR_HOME;
                        cmd.sweep_clear = 1'b1;
                        state_next      = S_CLEAR;
                    end
                    default: begin
                        cmd.read_issue = 1'b1;
                    end
                endcase
            end
            S_SCROLL: begin
                cmd.copy_step = 1'b1;
                if (stat.copy_last) begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                state_next = S_BLANK;
            end
            S_BLANK, S_CLEAR: begin
                cmd.blank_step = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    s_ready      = 1'b1;
                    if (s_valid) begin
                        cmd.load   = 1'b1;
                        state_next = S_DECODE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### src/text_console_char_engine_core.sv
// Put, move and read pass through the decode and done states; the done state loads the
// registered result once the output is free, and can take the next item in that step.
// LF, or a character put in the last column, on the last row scrolls: 1920 cells copy
// up a row, a flush state follows, and the 80 cells of the last row are blanked. Clear
// walks all 2000 cells of the screen memory one cell a cycle. Reset homes the cursor
// and sets colours to 15 on 0; screen contents are undefined until the first clear.
// ----------------------------------------------------------------------------
// text_console_char_engine_core
// Character-cell text console: cursor handling, scroll, clear and cell read.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_engine_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire tcon_pkg::item_t            s_item,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output tcon_pkg::result_t               m_result,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_addr,
    input  wire logic [tcon_pkg::CLR_W-1:0] cfg_wdata
);

    tcon_pkg::cmd_t  cmd;
    tcon_pkg::stat_t stat;

    tcon_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tcon_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .result    (m_result)
    );

endmodule

`default_nettype wire

### verif/text_console_char_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_char_engine_core_tb
// Self-checking bench for the text console engine. A scoreboard keeps its
// own screen, cursor and colours, predicts the cursor report and cell data of
// every accepted command and checks each result in order. Directed commands
// cover the edges of the cursor and scroll behaviour; random phases with
// different colour settings, idling on both channels and back-pressure
// follow.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_engine_core_tb;

    import tcon_pkg::*;

    localparam int SETTLE_CYCLES = 2100;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 5;
    localparam int PER_PHASE     = 146;

    class console_scoreboard;
        logic [CELL_W-1:0] cells [CELLS];
        int                cursor_x = 0;
        int                cursor_y = 0;
        logic [CLR_W-1:0]  fg = 4'd15;
        logic [CLR_W-1:0]  bg = 4'd0;
        result_t           expected [$];
        int                errors = 0;
        int                checked = 0;
        int                noted = 0;
        int                scrolls = 0;
        int                clears = 0;
        int                reads = 0;

        function int pending();
            return expected.size();
        endfunction

        function void set_colours(logic [CLR_W-1:0] f, logic [CLR_W-1:0] b);
            fg = f;
            bg = b;
        endfunction

        function logic [CELL_W-1:0] paint(logic [7:0] c);
            return {bg, fg, c};
        endfunction

        function void feed_line();
            cursor_x = 0;
            if (cursor_y < ROWS - 1) begin
                cursor_y++;
            end else begin
                for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
                for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = paint(CH_BLANK);
                scrolls++;
            end
        endfunction

        function void put_byte(logic [7:0] c);
            if (c == CH_CR) begin
                cursor_x = 0;
            end else if (c == CH_LF) begin
                feed_line();
            end else if (c == CH_BS) begin
                if (cursor_x > 0) cursor_x--;
                else if (cursor_y > 0) cursor_y--;
            end else begin
                cells[cursor_y * COLUMNS + cursor_x] = paint(c);
                cursor_x++;
                if (cursor_x >= COLUMNS) feed_line();
            end
        endfunction

        function void note_item(item_t it);
            int                c_lim;
            int                r_lim;
            logic [CELL_W-1:0] data;
            result_t           want;
            c_lim = (it.col > COLUMNS - 1) ? COLUMNS - 1 : int'(it.col);
            r_lim = (it.row > ROWS - 1) ? ROWS - 1 : int'(it.row);
            data  = '0;
            noted++;
            case (it.op)
                OP_PUT: put_byte(it.ch);
                OP_MOVE: begin
                    cursor_x = c_lim;
                    cursor_y = r_lim;
                end
                OP_CLEAR: begin
                    foreach (cells[i]) cells[i] = paint(CH_BLANK);
                    cursor_x = 0;
                    cursor_y = 0;
                    clears++;
                end
                default: begin
                    data = cells[r_lim * COLUMNS + c_lim];
                    reads++;
                end
            endcase
            want.cursor_col   = COL_W'(cursor_x);
            want.cursor_row   = ROW_W'(cursor_y);
            want.cursor_index = IDX_W'(cursor_y * COLUMNS + cursor_x);
            want.cell_data    = data;
            expected.push_back(want);
        endfunction

        function void flag(string msg);
            errors++;
            $display("%0t ns: %s", $time, msg);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
                flag($sformatf("%s mismatch: expected %0d, actual %0d", field, want, got));
        endfunction

        function void check_result(result_t got);
            result_t want;
            checked++;
            if (expected.size() == 0) begin
                flag($sformatf("result with no command pending: expected none, actual %h", got));
                return;
            end
            want = expected.pop_front();
            compare_field("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
            compare_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
            compare_field("cursor_index", 32'(want.cursor_index), 32'(got.cursor_index));
            compare_field("cell_data", 32'(want.cell_data), 32'(got.cell_data));
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    item_t            s_item = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    result_t          m_result;
    logic             cfg_we = 1'b0;
    logic             cfg_addr = 1'b0;
    logic [CLR_W-1:0] cfg_wdata = '0;

    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int settings = 1;

    console_scoreboard sb = new();

    always #4 aclk = ~aclk;

    text_console_char_engine_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    function automatic item_t mk(op_t op, logic [7:0] ch, logic [7:0] col, logic [7:0] row);
        item_t it;
        it.op  = op;
        it.ch  = ch;
        it.col = col;
        it.row = row;
        return it;
    endfunction

    function automatic item_t pick_item();
        item_t it;
        int    sel;
        int    roll;
        it.op  = 2'($urandom_range(3));
        it.ch  = 8'($urandom_range(255));
        it.col = 8'($urandom_range(255));
        it.row = 8'($urandom_range(255));
        sel    = $urandom_range(99);
        roll   = $urandom_range(99);
        if (sel < 62) begin
            it.op = OP_PUT;
            if (roll < 7) it.ch = CH_LF;
            else if (roll < 11) it.ch = CH_CR;
            else if (roll < 18) it.ch = CH_BS;
        end else if (sel < 97) begin
            it.op = (sel < 74) ? OP_MOVE : OP_READ;
            if (roll < 50) begin
                it.col = 8'($urandom_range(COLUMNS - 1));
                it.row = 8'($urandom_range(ROWS - 1));
            end
        end else begin
            it.op = OP_CLEAR;
        end
        return it;
    endfunction

    task automatic send_item(item_t it);
        while (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
    endtask

    // drop valid, drain results, then let any scroll or clear finish
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_colours(logic [CLR_W-1:0] f, logic [CLR_W-1:0] b);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_FG;
        cfg_wdata <= f;
        @(posedge aclk);
        cfg_addr  <= REG_BG;
        cfg_wdata <= b;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_colours(f, b);
        settings++;
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_result);
    end

    initial begin
        #50_000_000;
        $display("** text_console_char_engine_core: FAILED **");
        $finish;
    end

    initial begin
        item_t            directed [$];
        logic [CLR_W-1:0] f_sel;
        logic [CLR_W-1:0] b_sel;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed.push_back(mk(OP_CLEAR, 8'd0, 8'd0, 8'd0));
        directed.push_back(mk(OP_READ, 8'd0, 8'd0, 8'd0));
        directed.push_back(mk(OP_PUT, 8'd65, 8'd0, 8'd0));
        directed.push_back(mk(OP_PUT, 8'd0, 8'd255, 8'd255));
        directed.push_back(mk(OP_PUT, 8'd255, 8'd0, 8'd0));
        directed.push_back(mk(OP_PUT, 8'd9, 8'd0, 8'd0));
        directed.push_back(mk(OP_READ, 8'd0, 8'd1, 8'd0));
        directed.push_back(mk(OP_MOVE, 8'd0, 8'd255, 8'd255));
        directed.push_back(mk(OP_READ, 8'd0, 8'd255, 8'd255));
        directed.push_back(mk(OP_PUT, 8'd90, 8'd0, 8'd0));
        directed.push_back(mk(OP_READ, 8'd0, 8'd79, 8'd23));
        directed.push_back(mk(OP_READ, 8'd0, 8'd0, 8'd0));
        directed.push_back(mk(OP_PUT, 8'd98, 8'd0, 8'd0));
        directed.push_back(mk(OP_PUT, CH_CR, 8'd0, 8'd0));
        directed.push_back(mk(OP_PUT, CH_BS, 8'd0, 8'd0));
        directed.push_back(mk(OP_MOVE, 8'd0, 8'd5, 8'd3));
        directed.push_back(mk(OP_PUT, CH_BS, 8'd0, 8'd0));
        directed.push_back(mk(OP_MOVE, 8'd0, 8'd0, 8'd0));
        directed.push_back(mk(OP_PUT, CH_BS, 8'd0, 8'd0));
        directed.push_back(mk(OP_PUT, CH_LF, 8'd0, 8'd0));
        directed.push_back(mk(OP_MOVE, 8'd0, 8'd79, 8'd0));
        directed.push_back(mk(OP_PUT, 8'd113, 8'd0, 8'd0));
        directed.push_back(mk(OP_MOVE, 8'd0, 8'd0, 8'd24));
        directed.push_back(mk(OP_PUT, CH_LF, 8'd0, 8'd0));
        directed.push_back(mk(OP_READ, 8'd0, 8'd80, 8'd25));
        foreach (directed[i]) send_item(directed[i]);

        for (int p = 1; p <= PHASES; p++) begin
            settle();
            case (p)
                1: begin f_sel = 4'd0;  b_sel = 4'd15; end
                2: begin f_sel = 4'd0;  b_sel = 4'd0;  end
                3: begin f_sel = 4'd15; b_sel = 4'd15; end
                default: begin
                    f_sel = CLR_W'($urandom_range(15));
                    b_sel = CLR_W'($urandom_range(15));
                end
            endcase
            write_colours(f_sel, b_sel);
            calm = (p == 1);
            if (p == 3) hold_req = 1'b1;
            for (int n = 0; n < PER_PHASE; n++) begin
                if (p == 2 && n == PER_PHASE / 2) begin
                    s_valid <= 1'b0;
                    while (sb.pending() != 0) @(posedge aclk);
                end
                send_item(pick_item());
            end
        end
        settle();

        $display("Covered %0d commands over %0d colour settings: %0d scrolls, %0d clears,",
                 sb.noted, settings, sb.scrolls, sb.clears);
        $display("%0d cell reads; %0d results checked, %0d mismatches.",
                 sb.reads, sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("** text_console_char_engine_core: PASSED **");
        end else begin
            $display("** text_console_char_engine_core: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
